[hdl/btpwp_pkg.sv]
// package for the byte to prefix word packer: widths, constants, queue entry type and group length clamp
`timescale 1ns / 1ps

package btpwp_pkg;

    localparam int WORD_BITS   = 30;
    localparam int BYTE_BITS   = 8;
    localparam int CNT_BITS    = 5;
    localparam int REM_BITS    = 4;
    localparam int PAD_BITS    = WORD_BITS - BYTE_BITS;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CNT_BITS-1:0] PREFIX_RESET = CNT_BITS'(WORD_BITS);
    localparam logic [CNT_BITS-1:0] PREFIX_MAX   = CNT_BITS'(WORD_BITS);
    localparam logic [REM_BITS-1:0] BYTE_COUNT   = REM_BITS'(BYTE_BITS);

    // one byte of the stream as it waits in the queue
    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 last_byte;
    } item_t;

    // clamp the configured group length into 1 .. WORD_BITS
    function automatic logic [CNT_BITS-1:0] group_len(input logic [CNT_BITS-1:0] k);
        logic [CNT_BITS-1:0] g;
        g = k;
        if (k == '0) begin
            g = CNT_BITS'(1);
        end else if (k > PREFIX_MAX) begin
            g = PREFIX_MAX;
        end
        return g;
    endfunction

endpackage

[hdl/btpwp_queue.sv]
// front part: accepts input bytes into a two-entry queue
`timescale 1ns / 1ps

module btpwp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  btpwp_pkg::item_t      in_item,
    output logic                  q_valid,
    input  logic                  q_pop,
    output btpwp_pkg::item_t      q_item
);

    btpwp_pkg::item_t mem_reg [btpwp_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign s_ready = (count_reg != 2'(btpwp_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[hdl/btpwp_back.sv]
// back part: splits queued bytes into groups and drives the result register
`timescale 1ns / 1ps

module btpwp_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [btpwp_pkg::CNT_BITS-1:0]       prefix_bits,
    input  logic                                 q_valid,
    output logic                                 q_pop,
    input  btpwp_pkg::item_t                     q_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [btpwp_pkg::WORD_BITS-1:0]      m_packed_word,
    output logic [btpwp_pkg::CNT_BITS-1:0]       m_bit_count,
    output logic                                 m_last_word
);

    // current byte being split
    logic                                active_reg, active_next;
    logic [btpwp_pkg::BYTE_BITS-1:0]     rem_reg, rem_next;
    logic [btpwp_pkg::REM_BITS-1:0]      rem_cnt_reg, rem_cnt_next;
    logic                                last_reg, last_next;
    // gathered group
    logic [btpwp_pkg::WORD_BITS-1:0]     buf_reg, buf_next;
    logic [btpwp_pkg::CNT_BITS-1:0]      cnt_reg, cnt_next;
    // result register
    logic                                out_valid_reg, out_valid_next;
    logic [btpwp_pkg::WORD_BITS-1:0]     out_word_reg, out_word_next;
    logic [btpwp_pkg::CNT_BITS-1:0]      out_cnt_reg, out_cnt_next;
    logic                                out_last_reg, out_last_next;

    logic [btpwp_pkg::CNT_BITS-1:0]      k_eff;
    logic [btpwp_pkg::CNT_BITS-1:0]      need;
    logic [btpwp_pkg::REM_BITS-1:0]      take;
    logic [btpwp_pkg::REM_BITS-1:0]      rem_left;
    logic [btpwp_pkg::BYTE_BITS-1:0]     take_mask;
    logic [btpwp_pkg::BYTE_BITS-1:0]     rem_shift;
    logic [btpwp_pkg::WORD_BITS-1:0]     chunk;
    logic [btpwp_pkg::WORD_BITS-1:0]     word;
    logic [btpwp_pkg::CNT_BITS:0]        new_cnt;
    logic                                full;
    logic                                final_bit;
    logic                                emit;
    logic                                can_load;
    logic                                step_go;
    logic                                byte_done;

    assign m_valid       = out_valid_reg;
    assign m_packed_word = out_word_reg;
    assign m_bit_count   = out_cnt_reg;
    assign m_last_word   = out_last_reg;

    // one step: take bits up to the end of the group or of the byte
    always_comb begin
        k_eff = btpwp_pkg::group_len(prefix_bits);
        if (cnt_reg >= k_eff) begin
            need = btpwp_pkg::CNT_BITS'(1);
        end else begin
            need = k_eff - cnt_reg;
        end
        if (need < {1'b0, rem_cnt_reg}) begin
            take = need[btpwp_pkg::REM_BITS-1:0];
        end else begin
            take = rem_cnt_reg;
        end
        rem_left  = rem_cnt_reg - take;
        take_mask = ~({btpwp_pkg::BYTE_BITS{1'b1}} >> take);
        rem_shift = rem_reg << take;
        chunk     = {rem_reg & take_mask, {btpwp_pkg::PAD_BITS{1'b0}}} >> cnt_reg;
        word      = buf_reg | chunk;
        new_cnt   = {1'b0, cnt_reg} + {2'b00, take};
        full      = ({1'b0, take} == need);
        final_bit = last_reg && (rem_left == '0);
        emit      = full || final_bit;
        can_load  = !out_valid_reg || m_ready;
        step_go   = active_reg && (!emit || can_load);
    end

    // group and byte state update
    always_comb begin
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        rem_cnt_next = rem_cnt_reg;
        byte_done    = 1'b0;
        if (step_go) begin
            if (!emit) begin
                buf_next  = word;
                cnt_next  = new_cnt[btpwp_pkg::CNT_BITS-1:0];
                byte_done = 1'b1;
            end else if (rem_left == '0) begin
                buf_next  = '0;
                cnt_next  = '0;
                byte_done = 1'b1;
            end else if (!last_reg && ({1'b0, rem_left} < k_eff)) begin
                // leftover bits start the next group without completing it
                buf_next  = {rem_shift, {btpwp_pkg::PAD_BITS{1'b0}}};
                cnt_next  = {1'b0, rem_left};
                byte_done = 1'b1;
            end else begin
                buf_next     = '0;
                cnt_next     = '0;
                rem_next     = rem_shift;
                rem_cnt_next = rem_left;
            end
        end
        q_pop       = q_valid && (!active_reg || byte_done);
        active_next = active_reg;
        last_next   = last_reg;
        if (q_pop) begin
            active_next  = 1'b1;
            rem_next     = q_item.data_byte;
            rem_cnt_next = btpwp_pkg::BYTE_COUNT;
            last_next    = q_item.last_byte;
        end else if (byte_done) begin
            active_next = 1'b0;
        end
    end

    // result register load and drain
    always_comb begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        if (step_go && emit) begin
            out_valid_next = 1'b1;
            out_word_next  = word;
            out_cnt_next   = new_cnt[btpwp_pkg::CNT_BITS-1:0];
            out_last_next  = final_bit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            buf_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        rem_cnt_reg  <= rem_cnt_next;
        last_reg     <= last_next;
        out_word_reg <= out_word_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

endmodule

[hdl/byte_to_prefix_word_packer_unit.sv]
// Top level of the byte to prefix word packer.
// Throughput: one byte per cycle while each byte closes at most one group (groups of 8+
// bits) and m_ready holds; a last byte that closes a group before its final bit stays in
// the splitter while its remaining bits flush; shorter groups give one word per cycle
// while m_ready holds, and hold off input. Reset (aresetn low, synchronous) empties queue
// and result register, clears the group, and sets prefix_bits to 30.
`timescale 1ns / 1ps

module byte_to_prefix_word_packer_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [btpwp_pkg::CNT_BITS-1:0]       cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [btpwp_pkg::BYTE_BITS-1:0]      s_data_byte,
    input  logic                                 s_last_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [btpwp_pkg::WORD_BITS-1:0]      m_packed_word,
    output logic [btpwp_pkg::CNT_BITS-1:0]       m_bit_count,
    output logic                                 m_last_word
);

    logic [btpwp_pkg::CNT_BITS-1:0] prefix_bits_reg, prefix_bits_next;
    btpwp_pkg::item_t               in_item;
    btpwp_pkg::item_t               q_item;
    logic                           q_valid;
    logic                           q_pop;

    // configuration register transfer
    assign cfg_ready        = 1'b1;
    assign prefix_bits_next = (cfg_valid && cfg_ready) ? cfg_data : prefix_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_bits_reg <= btpwp_pkg::PREFIX_RESET;
        end else begin
            prefix_bits_reg <= prefix_bits_next;
        end
    end

    assign in_item.data_byte = s_data_byte;
    assign in_item.last_byte = s_last_byte;

    // input queue
    btpwp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    // splitter and result register
    btpwp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .prefix_bits   (prefix_bits_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_word (m_packed_word),
        .m_bit_count   (m_bit_count),
        .m_last_word   (m_last_word)
    );

endmodule

[tb/sv/packed_word_checker.sv]
// checker for the byte to prefix word packer: predicts packed words and compares results
`timescale 1ns / 1ps

module packed_word_checker
    import btpwp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CNT_BITS-1:0]  cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [BYTE_BITS-1:0] s_data_byte,
    input  logic                 s_last_byte,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [WORD_BITS-1:0] m_packed_word,
    input  logic [CNT_BITS-1:0]  m_bit_count,
    input  logic                 m_last_word,
    output int                   mismatches,
    output int                   words_pending
);

    typedef struct {
        logic [WORD_BITS-1:0] word;
        logic [CNT_BITS-1:0]  count;
        logic                 last_flag;
    } packed_word_t;

    // words predicted but not yet seen on the result channel
    packed_word_t expected_words[$];

    // shadow of the group length register and the partial group
    logic [CNT_BITS-1:0]  group_len_cfg = PREFIX_RESET;
    logic [WORD_BITS-1:0] gather_bits   = '0;
    int                   gather_fill   = 0;
    int                   error_total   = 0;

    initial begin
        mismatches    = 0;
        words_pending = 0;
    end

    // split one byte msb first into groups, queueing every closed group
    task automatic split_byte(input logic [BYTE_BITS-1:0] data, input logic last_flag);
        int           k;
        int           b;
        logic         final_bit;
        packed_word_t w;
        if (group_len_cfg == '0) begin
            k = 1;
        end else if (int'(group_len_cfg) > WORD_BITS) begin
            k = WORD_BITS;
        end else begin
            k = int'(group_len_cfg);
        end
        for (b = BYTE_BITS - 1; b >= 0; b--) begin
            final_bit = last_flag && (b == 0);
            if (data[b]) begin
                gather_bits[WORD_BITS-1-gather_fill] = 1'b1;
            end
            gather_fill++;
            // a group closes when full, or on the packet's final bit
            if (gather_fill >= k || final_bit) begin
                w.word      = gather_bits;
                w.count     = CNT_BITS'(gather_fill);
                w.last_flag = final_bit;
                expected_words.push_back(w);
                gather_bits = '0;
                gather_fill = 0;
            end
        end
    endtask

    // watch every transfer on the three channels
    always @(posedge aclk) begin : watch
        packed_word_t want;
        if (!aresetn) begin
            group_len_cfg = PREFIX_RESET;
            gather_bits   = '0;
            gather_fill   = 0;
            expected_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                group_len_cfg = cfg_data;
            end
            if (s_valid && s_ready) begin
                split_byte(s_data_byte, s_last_byte);
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word: packed_word %h bit_count %0d last_word %0b",
                             $time, m_packed_word, m_bit_count, m_last_word);
                    error_total++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_packed_word !== want.word) begin
                        $display("%0t: packed_word expected %h actual %h",
                                 $time, want.word, m_packed_word);
                        error_total++;
                    end
                    if (m_bit_count !== want.count) begin
                        $display("%0t: bit_count expected %0d actual %0d",
                                 $time, want.count, m_bit_count);
                        error_total++;
                    end
                    if (m_last_word !== want.last_flag) begin
                        $display("%0t: last_word expected %0b actual %0b",
                                 $time, want.last_flag, m_last_word);
                        error_total++;
                    end
                end
            end
        end
        mismatches    <= error_total;
        words_pending <= expected_words.size();
    end

endmodule

[tb/sv/tb_byte_to_prefix_word_packer_unit.sv]
// testbench top for the byte to prefix word packer: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_byte_to_prefix_word_packer_unit;
    import btpwp_pkg::*;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic [CNT_BITS-1:0]  cfg_data    = '0;
    logic                 s_valid     = 1'b0;
    logic [BYTE_BITS-1:0] s_data_byte = '0;
    logic                 s_last_byte = 1'b0;
    logic                 m_ready     = 1'b0;
    logic                 cfg_ready;
    logic                 s_ready;
    logic                 m_valid;
    logic [WORD_BITS-1:0] m_packed_word;
    logic [CNT_BITS-1:0]  m_bit_count;
    logic                 m_last_word;

    int fail_count;
    int words_pending;

    // flow control knobs
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;

    // group lengths for the random phases, extremes included
    logic [CNT_BITS-1:0] phase_len[8] = '{5'd30, 5'd1, 5'd8, 5'd13, 5'd1, 5'd31, 5'd5, 5'd0};

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    byte_to_prefix_word_packer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_word (m_packed_word),
        .m_bit_count   (m_bit_count),
        .m_last_word   (m_last_word)
    );

    packed_word_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_word (m_packed_word),
        .m_bit_count   (m_bit_count),
        .m_last_word   (m_last_word),
        .mismatches    (fail_count),
        .words_pending (words_pending)
    );

    // result side ready, with random stalls and an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests > holds_served) begin
            m_ready      <= 1'b0;
            hold_left    <= 80;
            holds_served <= holds_served + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one byte, idling cycle by cycle at random first, and wait for its transfer
    task automatic send_byte(input logic [BYTE_BITS-1:0] data, input logic last_flag);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= data;
        s_last_byte <= last_flag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering, drain every expected word, then let the splitter settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_group_len(input logic [CNT_BITS-1:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // random packet; now and then the closing flag is left off
    task automatic send_packet(input int len);
        int               i;
        logic [BYTE_BITS-1:0] data;
        for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0: data = '0;
                1: data = '1;
                default: data = BYTE_BITS'($urandom_range(0, 255));
            endcase
            send_byte(data, (i == len - 1) && ($urandom_range(0, 9) != 0));
        end
    endtask

    // run timeout
    initial begin
        #2_000_000;
        $display("tb_byte_to_prefix_word_packer_unit NOT OK");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int sent;
        int len;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset group length of 30: one full word, then a two-bit flush
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        wait_idle();

        // single-bit groups: eight words from one byte
        write_group_len(5'd1);
        send_byte(8'h80, 1'b1);
        wait_idle();

        // exact fit on the last byte
        write_group_len(5'd8);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        wait_idle();

        // zero length acts as one
        write_group_len(5'd0);
        send_byte(8'h5A, 1'b1);
        wait_idle();

        // length above the word acts as a full word
        write_group_len(5'd31);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
        wait_idle();

        // gather 16 bits, then shrink the group: the next bit closes a long word
        write_group_len(5'd30);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h96, 1'b0);
        wait_idle();
        write_group_len(5'd3);
        send_byte(8'h7E, 1'b1);
        wait_idle();

        // two exact nibbles on a last byte
        write_group_len(5'd4);
        send_byte(8'hF0, 1'b1);

        // random packets over all idle modes and several group lengths
        for (phase = 0; phase < 8; phase++) begin
            wait_idle();
            write_group_len(phase_len[phase]);
            case (phase % 4)
                0: begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct   = 73;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 73;
                end
                default: begin
                    send_idle_pct   = 26;
                    recv_stall_pct <= 26;
                end
            endcase
            // long receiver hold-off while bytes keep coming
            if (phase == 0) begin
                hold_requests <= hold_requests + 1;
            end
            sent = 0;
            while (sent < 28) begin
                len = $urandom_range(1, 10);
                send_packet(len);
                sent += len;
            end
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && words_pending == 0) begin
            $display("tb_byte_to_prefix_word_packer_unit OK");
        end else begin
            $display("tb_byte_to_prefix_word_packer_unit NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
hdl/btpwp_pkg.sv
hdl/btpwp_queue.sv
hdl/btpwp_back.sv
hdl/byte_to_prefix_word_packer_unit.sv
tb/sv/packed_word_checker.sv
tb/sv/tb_byte_to_prefix_word_packer_unit.sv
